@@ rtl/lcdww_pkg.sv @@
// lcdww_pkg: shared types and constants for the character lcd word wrap block
// used by lcdww_ctrl, lcdww_dp and char_lcd_word_wrap; no dependencies
`default_nettype none

package lcdww_pkg;

  // screen geometry and held word depth
  localparam int unsigned COLUMNS_DEF = 16;
  localparam int unsigned STORE_DEPTH = 16;

  // lcd byte codes
  localparam logic [7:0] CMD_LINE2  = 8'hC0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h80;
  localparam logic [7:0] SPACE_CODE = 8'h20;

  // result kind carried on tuser
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_PAUSE = 2'd2
  } kind_e;

  // byte source for an emitted item
  typedef enum logic [2:0] {
    BSEL_LINE2 = 3'd0,
    BSEL_CLEAR = 3'd1,
    BSEL_HOME  = 3'd2,
    BSEL_ZERO  = 3'd3,
    BSEL_CHAR  = 3'd4,
    BSEL_SPACE = 3'd5,
    BSEL_STORE = 3'd6
  } bsel_e;

  // cursor update
  typedef enum logic [2:0] {
    CUR_KEEP = 3'd0,
    CUR_INC  = 3'd1,
    CUR_SP1  = 3'd2,
    CUR_COL  = 3'd3,
    CUR_ZERO = 3'd4
  } cur_op_e;

  // what the character being shown comes from
  typedef enum logic [1:0] {
    SRC_CHAR  = 2'd0,
    SRC_SPACE = 2'd1,
    SRC_STORE = 2'd2
  } src_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    store_wr;
    logic    emit;
    kind_e   kind;
    bsel_e   bsel;
    cur_op_e cur_op;
    logic    k_clr;
    logic    k_inc;
    logic    res_done;
    logic    space_set;
    logic    fin_clr;
    logic    flush;
  } lcdww_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go;
    logic pending;
    logic is_space;
    logic fin;
    logic chk_wrap;
    logic fits;
    logic sp_lt_col;
    logic cur_eq_col;
    logic cur_eq_2col;
    logic k_done;
  } lcdww_stat_t;

endpackage

`default_nettype wire

@@ rtl/char_lcd_word_wrap.sv @@
// char_lcd_word_wrap: greedy word wrap for a two-line character lcd
// top level; uses lcdww_pkg, lcdww_ctrl and lcdww_dp
//
// Usage: message characters enter on the s_axis channel, one item each, with
// tlast marking the last character of a message. For each character the block
// sends zero or more lcd items on m_axis: tdata is the byte, tuser its kind
// (data, command, pause before clear) and tlast flags the last item caused by
// that character. A character held back inside a word causes no items.
// Sequence: a character is taken in S_IDLE and decoded in S_DISP, then the
// sequencer emits its lcd items one per step and a final S_FIN step releases
// the last one with tlast; each item passes through a hold stage into the
// output register. A character that settles a held word adds the wrap
// decision, a loop step and a show step per held character, and a step per
// extra command item.
// The sequencer works on one character at a time; s_axis_tready_o is high only
// while it waits for the next character.
// Reset clears the cursor, the pending space and the held word count; the
// held word store itself is not cleared, it is only read after being written.
// When the receiver stalls, a finished item waits in the output register and
// the sequencer keeps one more item in a hold stage, then waits.
`default_nettype none

module char_lcd_word_wrap #(
  parameter int unsigned COLUMNS = lcdww_pkg::COLUMNS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // character input
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire  [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  wire        s_axis_tlast_i,   // is_final
  // lcd item output
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_value
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o    // run_end
);
  import lcdww_pkg::*;

  lcdww_cmd_t  cmd;
  lcdww_stat_t stat;

  // sequencer
  lcdww_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // cursor, word store and output stage
  lcdww_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .char_i    (s_axis_tdata_i),
    .fin_i     (s_axis_tlast_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_kind_o  (m_axis_tuser_o),
    .m_byte_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

@@ rtl/lcdww_ctrl.sv @@
// lcdww_ctrl: sequencer for the word wrap block, at most one lcd item per step
// uses lcdww_pkg; drives lcdww_dp through command and status structs
`default_nettype none

module lcdww_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      s_valid_i,
  output logic                     s_ready_o,
  input  wire lcdww_pkg::lcdww_stat_t stat_i,
  output lcdww_pkg::lcdww_cmd_t    cmd_o
);
  import lcdww_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RHEAD = 4'd2;
  localparam logic [3:0] S_RCLR  = 4'd3;
  localparam logic [3:0] S_RHOME = 4'd4;
  localparam logic [3:0] S_RLOOP = 4'd5;
  localparam logic [3:0] S_SPRE  = 4'd6;
  localparam logic [3:0] S_SCLR  = 4'd7;
  localparam logic [3:0] S_SHOME = 4'd8;
  localparam logic [3:0] S_SDATA = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       then_space_q, then_space_d;
  src_e       src_q, src_d;
  bsel_e      data_bsel;

  // byte source of the character being shown
  always_comb begin
    case (src_q)
      SRC_CHAR:  data_bsel = BSEL_CHAR;
      SRC_SPACE: data_bsel = BSEL_SPACE;
      SRC_STORE: data_bsel = BSEL_STORE;
      default:   data_bsel = BSEL_ZERO;
    endcase
  end

  assign s_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d      = state_q;
    then_space_d = then_space_q;
    src_d        = src_q;
    cmd_o        = '0;
    cmd_o.kind   = KIND_DATA;
    cmd_o.bsel   = BSEL_ZERO;
    cmd_o.cur_op = CUR_KEEP;

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DISP;
        end
      end

      S_DISP: begin
        if (stat_i.go) begin
          if (stat_i.pending && stat_i.is_space) begin
            then_space_d = 1'b1;
            state_d      = S_RHEAD;
          end else if (stat_i.pending) begin
            cmd_o.store_wr = 1'b1;
            then_space_d   = 1'b0;
            state_d        = stat_i.chk_wrap ? S_RHEAD : S_FIN;
          end else if (stat_i.is_space) begin
            src_d   = SRC_SPACE;
            state_d = S_SPRE;
          end else begin
            src_d   = SRC_CHAR;
            state_d = S_SPRE;
          end
        end
      end

      // wrap decision for the held word
      S_RHEAD: begin
        if (stat_i.go) begin
          cmd_o.k_clr = 1'b1;
          if (stat_i.fits) begin
            cmd_o.cur_op = CUR_SP1;
            state_d      = S_RLOOP;
          end else if (stat_i.sp_lt_col) begin
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = KIND_CMD;
            cmd_o.bsel   = BSEL_LINE2;
            cmd_o.cur_op = CUR_COL;
            state_d      = S_RLOOP;
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = KIND_PAUSE;
            cmd_o.bsel   = BSEL_ZERO;
            cmd_o.cur_op = CUR_ZERO;
            state_d      = S_RCLR;
          end
        end
      end

      S_RCLR: begin
        if (stat_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_CMD;
          cmd_o.bsel = BSEL_CLEAR;
          state_d    = S_RHOME;
        end
      end

      S_RHOME: begin
        if (stat_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_CMD;
          cmd_o.bsel = BSEL_HOME;
          state_d    = S_RLOOP;
        end
      end

      // show the held characters one by one
      S_RLOOP: begin
        if (stat_i.go) begin
          if (stat_i.k_done) begin
            cmd_o.res_done = 1'b1;
            if (then_space_q) begin
              src_d   = SRC_SPACE;
              state_d = S_SPRE;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            src_d   = SRC_STORE;
            state_d = S_SPRE;
          end
        end
      end

      // line and screen checks ahead of a character, then the character itself
      S_SPRE, S_SDATA: begin
        if (stat_i.go) begin
          if (state_q == S_SPRE && stat_i.cur_eq_col) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_CMD;
            cmd_o.bsel = BSEL_LINE2;
            state_d    = S_SDATA;
          end else if (state_q == S_SPRE && stat_i.cur_eq_2col) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_PAUSE;
            cmd_o.bsel = BSEL_ZERO;
            state_d    = S_SCLR;
          end else begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_DATA;
            cmd_o.bsel = data_bsel;
            case (src_q)
              SRC_SPACE: begin
                cmd_o.space_set = 1'b1;
                state_d         = S_FIN;
              end
              SRC_STORE: begin
                cmd_o.cur_op = CUR_INC;
                cmd_o.k_inc  = 1'b1;
                state_d      = S_RLOOP;
              end
              default: begin
                cmd_o.cur_op = CUR_INC;
                state_d      = S_FIN;
              end
            endcase
          end
        end
      end

      S_SCLR: begin
        if (stat_i.go) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_CMD;
          cmd_o.bsel = BSEL_CLEAR;
          state_d    = S_SHOME;
        end
      end

      S_SHOME: begin
        if (stat_i.go) begin
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = KIND_CMD;
          cmd_o.bsel   = BSEL_HOME;
          cmd_o.cur_op = CUR_ZERO;
          state_d      = S_SDATA;
        end
      end

      // end of message handling and release of the last item
      S_FIN: begin
        if (stat_i.go) begin
          if (stat_i.fin && stat_i.pending) begin
            then_space_d = 1'b0;
            state_d      = S_RHEAD;
          end else begin
            cmd_o.fin_clr = stat_i.fin;
            cmd_o.flush   = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      then_space_q <= 1'b0;
      src_q        <= SRC_CHAR;
    end else begin
      state_q      <= state_d;
      then_space_q <= then_space_d;
      src_q        <= src_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lcdww_dp.sv @@
// lcdww_dp: cursor, held word store and output registers of the word wrap block
// uses lcdww_pkg; commanded by lcdww_ctrl
`default_nettype none

module lcdww_dp #(
  parameter int unsigned COLUMNS = lcdww_pkg::COLUMNS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire lcdww_pkg::lcdww_cmd_t cmd_i,
  output lcdww_pkg::lcdww_stat_t   stat_o,
  input  wire  [7:0]               char_i,
  input  wire                      fin_i,
  output logic                     m_valid_o,
  input  wire                      m_ready_i,
  output logic [1:0]               m_kind_o,
  output logic [7:0]               m_byte_o,
  output logic                     m_last_o
);
  import lcdww_pkg::*;

  localparam int unsigned CUR_W  = $clog2(2 * COLUMNS + 1);
  localparam int unsigned WC_W   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SIDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CMP_W  = ((CUR_W > WC_W) ? CUR_W : WC_W) + 1;

  localparam logic [CUR_W-1:0] ColC  = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] Col2C = CUR_W'(2 * COLUMNS);
  localparam logic [CUR_W-1:0] OneC  = CUR_W'(1);

  // message state
  logic [CUR_W-1:0] cur_q, cur_d;
  logic [CUR_W-1:0] sp_q, sp_d;
  logic             pend_q, pend_d;
  logic [WC_W-1:0]  wc_q, wc_d;
  logic [WC_W-1:0]  k_q, k_d;
  logic [7:0]       char_q;
  logic             fin_q;
  logic [7:0]       store_q [STORE_DEPTH];

  // output hold stage and output register
  logic             hold_v_q;
  logic [1:0]       hold_kind_q;
  logic [7:0]       hold_byte_q;
  logic             out_v_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;

  logic [CUR_W-1:0] cells_left;
  logic [CMP_W-1:0] cl_x, wc_x, wc1_x;
  logic             sp_lt_col;
  logic             out_free;
  logic [7:0]       emit_byte;

  // cells left after the pending space
  assign sp_lt_col  = (sp_q < ColC);
  assign cells_left = sp_lt_col ? (ColC - sp_q - OneC) : (Col2C - sp_q - OneC);
  assign cl_x       = CMP_W'(cells_left);
  assign wc_x       = CMP_W'(wc_q);
  assign wc1_x      = wc_x + CMP_W'(1);

  assign out_free = !out_v_q || m_ready_i;

  // status for the controller
  always_comb begin
    stat_o             = '0;
    stat_o.go          = !hold_v_q || out_free;
    stat_o.pending     = pend_q;
    stat_o.is_space    = (char_q == SPACE_CODE);
    stat_o.fin         = fin_q;
    stat_o.chk_wrap    = (wc1_x > cl_x) || (wc1_x >= CMP_W'(STORE_DEPTH));
    stat_o.fits        = (wc_x <= cl_x);
    stat_o.sp_lt_col   = sp_lt_col;
    stat_o.cur_eq_col  = (cur_q == ColC);
    stat_o.cur_eq_2col = (cur_q == Col2C);
    stat_o.k_done      = (k_q == wc_q);
  end

  // byte of the item being emitted
  always_comb begin
    case (cmd_i.bsel)
      BSEL_LINE2: emit_byte = CMD_LINE2;
      BSEL_CLEAR: emit_byte = CMD_CLEAR;
      BSEL_HOME:  emit_byte = CMD_HOME;
      BSEL_CHAR:  emit_byte = char_q;
      BSEL_SPACE: emit_byte = SPACE_CODE;
      BSEL_STORE: emit_byte = store_q[k_q[SIDX_W-1:0]];
      default:    emit_byte = 8'h00;
    endcase
  end

  // next message state
  always_comb begin
    cur_d  = cur_q;
    sp_d   = sp_q;
    pend_d = pend_q;
    wc_d   = wc_q;
    k_d    = k_q;

    case (cmd_i.cur_op)
      CUR_INC:  cur_d = cur_q + OneC;
      CUR_SP1:  cur_d = sp_q + OneC;
      CUR_COL:  cur_d = ColC;
      CUR_ZERO: cur_d = '0;
      default:  cur_d = cur_q;
    endcase

    if (cmd_i.store_wr) begin
      wc_d = wc_q + WC_W'(1);
    end
    if (cmd_i.k_clr) begin
      k_d = '0;
    end else if (cmd_i.k_inc) begin
      k_d = k_q + WC_W'(1);
    end
    if (cmd_i.res_done) begin
      pend_d = 1'b0;
      wc_d   = '0;
    end
    if (cmd_i.space_set) begin
      sp_d   = cur_q;
      pend_d = 1'b1;
      wc_d   = '0;
    end
    if (cmd_i.fin_clr) begin
      cur_d  = '0;
      sp_d   = '0;
      pend_d = 1'b0;
      wc_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      sp_q     <= '0;
      pend_q   <= 1'b0;
      wc_q     <= '0;
      k_q      <= '0;
      fin_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      sp_q   <= sp_d;
      pend_q <= pend_d;
      wc_q   <= wc_d;
      k_q    <= k_d;
      if (cmd_i.accept) begin
        fin_q <= fin_i;
      end
      if (cmd_i.emit) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
      if ((cmd_i.emit || cmd_i.flush) && hold_v_q) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= char_i;
    end
    if (cmd_i.store_wr) begin
      store_q[wc_q[SIDX_W-1:0]] <= char_q;
    end
    if (cmd_i.emit) begin
      hold_kind_q <= cmd_i.kind;
      hold_byte_q <= emit_byte;
    end
    if ((cmd_i.emit || cmd_i.flush) && hold_v_q) begin
      out_kind_q <= hold_kind_q;
      out_byte_q <= hold_byte_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_kind_o  = out_kind_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;

  // checks
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= Col2C)
    else $error("cursor beyond the end of the screen");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q < Col2C)
    else $error("space position beyond the last cell");

  a_wc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (wc_q == '0))
    else $error("held characters without a pending space");

  a_wc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WC_W'(STORE_DEPTH))
    else $error("held word overran the store");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.flush && hold_v_q) |=> (out_v_q && out_last_q && !hold_v_q))
    else $error("last item of an input not released with tlast");

endmodule

`default_nettype wire

@@ dv/lcdww_checker.sv @@
// lcdww_checker: watches both stream channels of char_lcd_word_wrap, predicts the lcd items
// for every accepted character and compares them in order; uses lcdww_pkg
`timescale 1ns / 100ps

module lcdww_checker #(
  parameter int unsigned COLUMNS = lcdww_pkg::COLUMNS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_tvalid_i,
  input  wire        s_tready_i,
  input  wire  [7:0] s_tdata_i,
  input  wire        s_tlast_i,
  input  wire        m_tvalid_i,
  input  wire        m_tready_i,
  input  wire  [7:0] m_tdata_i,
  input  wire  [1:0] m_tuser_i,
  input  wire        m_tlast_i,
  output int         fail_count_o,
  output int         pend_count_o,
  output int         checked_count_o
);
  import lcdww_pkg::*;

  localparam int unsigned CUR_W     = $clog2(2 * COLUMNS + 1);
  localparam int unsigned LEN_W     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MAX_ITEMS = 48;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
    logic       run_end;
  } lcd_item_t;

  // predicted screen state
  logic [CUR_W-1:0] cursor;
  logic [CUR_W-1:0] space_cell;
  logic             word_held;
  logic [LEN_W-1:0] word_len;
  logic [7:0]       word_buf [STORE_DEPTH];

  lcd_item_t lcd_items_due[$];
  lcd_item_t step_items[$];
  lcd_item_t due;
  int        fails;
  int        checked;
  string     exp_txt;

  function automatic void add_item(kind_e k, logic [7:0] v);
    lcd_item_t it;
    it.kind    = k;
    it.code    = v;
    it.run_end = 1'b0;
    if (step_items.size() < MAX_ITEMS) step_items.push_back(it);
  endfunction

  // pause, clear, home, cursor back to the first cell
  function automatic void fresh_screen();
    add_item(KIND_PAUSE, 8'h00);
    add_item(KIND_CMD, CMD_CLEAR);
    add_item(KIND_CMD, CMD_HOME);
    cursor = '0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (cursor == COLUMNS) add_item(KIND_CMD, CMD_LINE2);
    if (cursor == 2 * COLUMNS) fresh_screen();
    add_item(KIND_DATA, c);
  endfunction

  // cells left on the line of the pending space
  function automatic int unsigned room_on_line();
    if (space_cell < COLUMNS) return COLUMNS - (space_cell + 1);
    return 2 * COLUMNS - (space_cell + 1);
  endfunction

  // settle the wrap decision and show the held word
  function automatic void place_word(bit fits);
    int unsigned k;
    if (fits) begin
      cursor = space_cell + 1'b1;
    end else if (space_cell < COLUMNS) begin
      add_item(KIND_CMD, CMD_LINE2);
      cursor = CUR_W'(COLUMNS);
    end else begin
      fresh_screen();
    end
    word_held = 1'b0;
    for (k = 0; k < word_len && k < STORE_DEPTH; k++) begin
      put_char(word_buf[k]);
      cursor++;
    end
    word_len = '0;
  endfunction

  function automatic void open_space();
    put_char(SPACE_CODE);
    space_cell = cursor;
    word_held  = 1'b1;
    word_len   = '0;
  endfunction

  // lcd items caused by one message character
  function automatic void predict_lcd_items(logic [7:0] c, logic fin);
    lcd_item_t tail;
    step_items.delete();
    if (word_held) begin
      if (c == SPACE_CODE) begin
        place_word(word_len <= room_on_line());
        open_space();
      end else begin
        word_buf[word_len % STORE_DEPTH] = c;
        word_len++;
        if (word_len > room_on_line()) place_word(1'b0);
        else if (word_len >= STORE_DEPTH) place_word(1'b1);
      end
    end else if (c == SPACE_CODE) begin
      open_space();
    end else begin
      put_char(c);
      cursor++;
    end
    // end of message settles any held word and starts over
    if (fin) begin
      if (word_held) place_word(word_len <= room_on_line());
      cursor     = '0;
      word_held  = 1'b0;
      space_cell = '0;
      word_len   = '0;
    end
    if (step_items.size() > 0) begin
      tail = step_items.pop_back();
      tail.run_end = 1'b1;
      step_items.push_back(tail);
    end
  endfunction

  // predict on accepted characters, then compare accepted lcd items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor     = '0;
      space_cell = '0;
      word_held  = 1'b0;
      word_len   = '0;
      lcd_items_due.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_lcd_items(s_tdata_i, s_tlast_i);
        foreach (step_items[i]) lcd_items_due.push_back(step_items[i]);
      end
      if (m_tvalid_i && m_tready_i) begin
        checked++;
        if (lcd_items_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected lcd item: expected none, got kind %0d byte %h end %b",
                   $time, m_tuser_i, m_tdata_i, m_tlast_i);
        end else begin
          due = lcd_items_due.pop_front();
          if (due.kind != kind_e'(m_tuser_i) || due.code != m_tdata_i ||
              due.run_end != m_tlast_i) begin
            fails++;
            exp_txt = $sformatf("kind %0d byte %h end %b", due.kind, due.code,
                                due.run_end);
            $display("%0t: lcd item mismatch: expected %s, got kind %0d byte %h end %b",
                     $time, exp_txt, m_tuser_i, m_tdata_i, m_tlast_i);
          end
        end
      end
    end
    fail_count_o    <= fails;
    pend_count_o    <= lcd_items_due.size();
    checked_count_o <= checked;
  end

endmodule

@@ dv/testbench.sv @@
// testbench: drives message characters into char_lcd_word_wrap and stalls its output
// at random; depends on lcdww_pkg, char_lcd_word_wrap and lcdww_checker
`timescale 1ns / 100ps

module testbench;
  import lcdww_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  int fail_count;
  int pend_count;
  int checked_count;
  int snd_idle_pct = 27;
  int rcv_idle_pct = 68;
  int chars_sent   = 0;
  int messages     = 0;
  int quiet_cycles = 0;

  char_lcd_word_wrap #(.COLUMNS(COLUMNS_DEF)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  lcdww_checker #(.COLUMNS(COLUMNS_DEF)) chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tlast_i       (s_tlast),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tuser_i       (m_tuser),
    .m_tlast_i       (m_tlast),
    .fail_count_o    (fail_count),
    .pend_count_o    (pend_count),
    .checked_count_o (checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lcd side backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one character, with a random gap in front, held until taken
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string txt, input bit fin_at_end);
    int i;
    for (i = 0; i < txt.len(); i++) send_char(txt[i], fin_at_end && i == txt.len() - 1);
  endtask

  // hold off the sender until every predicted lcd item has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pend_count != 0);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    if ($urandom_range(15) == 0) return c;
    while (c == SPACE_CODE) c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  // words split by spaces, mostly short words, a few longer than a line
  task automatic send_message();
    logic [7:0]  msg [$];
    int unsigned n_words;
    int unsigned wlen;
    int unsigned w;
    int unsigned i;
    n_words = $urandom_range(8, 1);
    if ($urandom_range(7) == 0) msg.push_back(SPACE_CODE);
    for (w = 0; w < n_words; w++) begin
      if (w != 0) begin
        msg.push_back(SPACE_CODE);
        if ($urandom_range(7) == 0) msg.push_back(SPACE_CODE);
      end
      wlen = ($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(9, 1);
      for (i = 0; i < wlen; i++) msg.push_back(word_char());
    end
    if ($urandom_range(7) == 0) msg.push_back(SPACE_CODE);
    foreach (msg[k]) send_char(msg[k], k == msg.size() - 1);
    messages++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single character messages: code zero, all ones, a lone final space
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(SPACE_CODE, 1'b1);
    // word too long for the rest of line 1 is decided early, then a final character on line 2
    send_text("ABCDEFGHIJKL wxyz", 1'b0);
    send_char(8'h21, 1'b1);
    // held word settled by the end of the message
    send_text("a bc", 1'b1);
    messages += 5;
    wait_drained();

    // sender idles little, receiver much
    while (chars_sent < 120) send_message();
    wait_drained();

    // sender idles much, receiver little
    snd_idle_pct = 68;
    rcv_idle_pct = 27;
    while (chars_sent < 220) send_message();

    // no idling at all
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (chars_sent < 310) send_message();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d characters in %0d messages, %0d lcd items checked",
             chars_sent, messages, checked_count);
    if (pend_count != 0)
      $display("%0t: %0d expected lcd items never came out", $time, pend_count);
    if (fail_count == 0 && pend_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
